@@ hw/rtl/epcal_pkg.sv @@
// Shared types, constants and calendar helpers for the epoch-to-calendar converter.
package epcal_pkg;

    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MLEN_W   = 22;

    localparam logic [EPOCH_W-1:0] SECS_COMMON_YEAR = 32'd31536000;
    localparam logic [EPOCH_W-1:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [EPOCH_W-1:0] SECS_DAY         = 32'd86400;
    localparam logic [EPOCH_W-1:0] SECS_HOUR        = 32'd3600;
    localparam logic [EPOCH_W-1:0] SECS_MINUTE      = 32'd60;

    localparam logic [YEAR_W-1:0]  FIRST_YEAR   = 12'd1970;
    localparam logic [YEAR_W-1:0]  CENTURY_2100 = 12'd2100;
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;

    // Which field the shared subtract/compare unit works on
    typedef enum logic [2:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE
    } epcal_phase_t;

    typedef struct packed {
        logic         load;     // take a new transaction into the working registers
        logic         advance;  // subtract one unit and bump the current field
        logic         publish;  // copy the working registers to the output stage
        epcal_phase_t phase;
    } epcal_cmd_t;

    typedef struct packed {
        logic fits;             // remainder holds at least one more unit of the phase
    } epcal_sts_t;

    // Gregorian leap test over 1970..2106: 2100 is the only non-leap century year in range
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != CENTURY_2100);
    endfunction

    // Seconds in a month of the given year type
    function automatic logic [MLEN_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
                                                     input logic            leap);
        logic [MLEN_W-1:0] secs;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: secs = 22'd2678400;
            4'd4, 4'd6, 4'd9, 4'd11:                    secs = 22'd2592000;
            4'd2:                       secs = leap ? 22'd2505600 : 22'd2419200;
            default:                                    secs = 22'd2678400;
        endcase
        return secs;
    endfunction

endpackage

@@ hw/rtl/epcal_dp.sv @@
// Datapath: working remainder, calendar counters and the output register stage.
module epcal_dp
    import epcal_pkg::*;
(
    input  logic                 aclk,
    input  logic [EPOCH_W-1:0]   s_epoch_seconds,
    input  epcal_cmd_t           cmd,
    output epcal_sts_t           sts,
    output logic [YEAR_W-1:0]    m_year,
    output logic [MONTH_W-1:0]   m_month,
    output logic [DAY_W-1:0]     m_day,
    output logic [HOUR_W-1:0]    m_hour,
    output logic [MINUTE_W-1:0]  m_minute,
    output logic [SEC_W-1:0]     m_seconds_part
);

    logic [EPOCH_W-1:0]  rem_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;

    logic [YEAR_W-1:0]   out_year_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [DAY_W-1:0]    out_day_reg;
    logic [HOUR_W-1:0]   out_hour_reg;
    logic [MINUTE_W-1:0] out_minute_reg;
    logic [SEC_W-1:0]    out_sec_reg;

    logic [EPOCH_W-1:0]  unit_len;
    logic                leap;
    logic                room;

    // Select the length of one unit for the current phase
    always_comb begin
        leap = is_leap(year_reg);
        room = 1'b1;
        case (cmd.phase)
            PH_YEAR:   unit_len = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            PH_MONTH: begin
                unit_len = {{(EPOCH_W-MLEN_W){1'b0}}, month_secs(month_reg, leap)};
                room     = (month_reg != MONTH_DEC);
            end
            PH_DAY:    unit_len = SECS_DAY;
            PH_HOUR:   unit_len = SECS_HOUR;
            PH_MINUTE: unit_len = SECS_MINUTE;
            default:   unit_len = SECS_MINUTE;
        endcase
        sts.fits = room && (rem_reg >= unit_len);
    end

    // Load, then peel off one unit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg    <= s_epoch_seconds;
            year_reg   <= FIRST_YEAR;
            month_reg  <= MONTH_JAN;
            day_reg    <= DAY_FIRST;
            hour_reg   <= '0;
            minute_reg <= '0;
        end else if (cmd.advance) begin
            rem_reg <= rem_reg - unit_len;
            case (cmd.phase)
                PH_YEAR:   year_reg   <= year_reg + 1'b1;
                PH_MONTH:  month_reg  <= month_reg + 1'b1;
                PH_DAY:    day_reg    <= day_reg + 1'b1;
                PH_HOUR:   hour_reg   <= hour_reg + 1'b1;
                PH_MINUTE: minute_reg <= minute_reg + 1'b1;
                default:   minute_reg <= minute_reg;
            endcase
        end
    end

    // Hold the finished transaction for the receiver
    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_year_reg   <= year_reg;
            out_month_reg  <= month_reg;
            out_day_reg    <= day_reg;
            out_hour_reg   <= hour_reg;
            out_minute_reg <= minute_reg;
            out_sec_reg    <= rem_reg[SEC_W-1:0];
        end
    end

    assign m_year         = out_year_reg;
    assign m_month        = out_month_reg;
    assign m_day          = out_day_reg;
    assign m_hour         = out_hour_reg;
    assign m_minute       = out_minute_reg;
    assign m_seconds_part = out_sec_reg;

endmodule

@@ hw/rtl/epcal_ctrl.sv @@
// Controller: sequences the conversion phases and owns both handshakes.
module epcal_ctrl
    import epcal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  epcal_sts_t sts,
    output epcal_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Decode commands from the current state
    always_comb begin
        cmd.load    = s_valid && (state_reg == ST_IDLE);
        cmd.publish = (state_reg == ST_DONE) && out_free;
        cmd.advance = 1'b0;
        cmd.phase   = PH_YEAR;
        unique case (state_reg)
            ST_YEAR:   cmd.phase = PH_YEAR;
            ST_MONTH:  cmd.phase = PH_MONTH;
            ST_DAY:    cmd.phase = PH_DAY;
            ST_HOUR:   cmd.phase = PH_HOUR;
            ST_MINUTE: cmd.phase = PH_MINUTE;
            default:   cmd.phase = PH_YEAR;
        endcase
        if ((state_reg != ST_IDLE) && (state_reg != ST_DONE)) begin
            cmd.advance = sts.fits;
        end
    end

    // Advance state and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Raise valid on publish, drop it once the receiver takes the transaction
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:   if (s_valid) state_reg <= ST_YEAR;
                ST_YEAR:   if (!sts.fits) state_reg <= ST_MONTH;
                ST_MONTH:  if (!sts.fits) state_reg <= ST_DAY;
                ST_DAY:    if (!sts.fits) state_reg <= ST_HOUR;
                ST_HOUR:   if (!sts.fits) state_reg <= ST_MINUTE;
                ST_MINUTE: if (!sts.fits) state_reg <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    a_load_starts_year: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_YEAR)
        else $error("accepted transaction did not start the year phase");

    a_done_waits_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && m_valid_reg && !m_ready |=> state_reg == ST_DONE)
        else $error("result stage overwritten while stalled");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_advance_needs_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> sts.fits && !cmd.load && !cmd.publish)
        else $error("subtract issued without a fitting unit");

endmodule

@@ hw/rtl/epoch_seconds_to_calendar.sv @@
// Top level: unsigned epoch seconds in, Gregorian date and time of day out.
//
// Usage:
//   Input channel s_valid/s_ready carries s_epoch_seconds, seconds since
//   1970-01-01 00:00:00. Result channel m_valid/m_ready carries m_year,
//   m_month, m_day, m_hour, m_minute and m_seconds_part, one result per
//   transaction, in order.
//   Conversion runs one transaction at a time by repeated subtraction in a
//   single subtract/compare unit: whole years, then months, days, hours
//   and minutes are removed one unit at a time, each phase closing once
//   its unit no longer fits, and the finished fields and the remaining
//   seconds are then published to the output register. The next
//   transaction is accepted only after the publish, when the converter
//   has returned to idle, so conversions never overlap.
//   s_ready is high only while the converter is idle; a finished result sits
//   in the output register, so a new transaction is taken while the result
//   still waits. If the receiver stalls, the next conversion completes and
//   then holds until the output register frees.
//   aresetn is synchronous and active low: it drops m_valid and returns the
//   converter to idle, discarding any transaction in progress.
module epoch_seconds_to_calendar
    import epcal_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [EPOCH_W-1:0]  s_epoch_seconds,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [YEAR_W-1:0]   m_year,
    output logic [MONTH_W-1:0]  m_month,
    output logic [DAY_W-1:0]    m_day,
    output logic [HOUR_W-1:0]   m_hour,
    output logic [MINUTE_W-1:0] m_minute,
    output logic [SEC_W-1:0]    m_seconds_part
);

    epcal_cmd_t cmd;
    epcal_sts_t sts;

    epcal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    epcal_dp u_dp (
        .aclk            (aclk),
        .s_epoch_seconds (s_epoch_seconds),
        .cmd             (cmd),
        .sts             (sts),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_seconds_part  (m_seconds_part)
    );

endmodule

@@ verif/epoch_calendar_checker.sv @@
// Checker for the epoch-to-calendar converter: watches both channels and compares results.
`timescale 1ns / 1ps

module epoch_calendar_checker
    import epcal_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [EPOCH_W-1:0]  s_epoch_seconds,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [YEAR_W-1:0]   m_year,
    input  logic [MONTH_W-1:0]  m_month,
    input  logic [DAY_W-1:0]    m_day,
    input  logic [HOUR_W-1:0]   m_hour,
    input  logic [MINUTE_W-1:0] m_minute,
    input  logic [SEC_W-1:0]    m_seconds_part,
    output int                  mismatches,
    output int                  dates_outstanding
);

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SEC_W-1:0]    second;
    } calendar_t;

    calendar_t expected_dates[$];
    calendar_t want;
    calendar_t got;

    initial begin
        mismatches        = 0;
        dates_outstanding = 0;
    end

    // Full Gregorian rule, centuries included
    function automatic logic gregorian_leap(input int unsigned yr);
        if (yr % 4 != 0) return 1'b0;
        if (yr % 100 != 0) return 1'b1;
        return (yr % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mo, input logic leap);
        case (mo)
            4, 6, 9, 11: return 30;
            MONTH_FEB:   return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Strip whole years, then whole months, then split the rest into d/h/m/s
    function automatic calendar_t to_calendar(input logic [EPOCH_W-1:0] secs);
        logic [EPOCH_W-1:0] rem;
        logic [EPOCH_W-1:0] span;
        int unsigned        yr;
        int unsigned        mo;
        calendar_t          c;
        rem = secs;
        yr  = FIRST_YEAR;
        span = gregorian_leap(yr) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
        while (rem >= span) begin
            rem  = rem - span;
            yr   = yr + 1;
            span = gregorian_leap(yr) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
        end
        mo = MONTH_JAN;
        while (mo < MONTH_DEC) begin
            span = days_in_month(mo, gregorian_leap(yr)) * SECS_DAY;
            if (rem < span) break;
            rem = rem - span;
            mo  = mo + 1;
        end
        c.year   = yr[YEAR_W-1:0];
        c.month  = mo[MONTH_W-1:0];
        c.day    = DAY_W'(1 + rem / SECS_DAY);
        rem      = rem % SECS_DAY;
        c.hour   = HOUR_W'(rem / SECS_HOUR);
        rem      = rem % SECS_HOUR;
        c.minute = MINUTE_W'(rem / SECS_MINUTE);
        c.second = SEC_W'(rem % SECS_MINUTE);
        return c;
    endfunction

    // Print one line per mismatch (capped) and count it
    task automatic report(input string what, input int unsigned exp_v, input int unsigned got_v);
        mismatches = mismatches + 1;
        if (mismatches <= 100)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    // Compare each result transaction against the oldest prediction, then record new inputs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_year, m_month, m_day, m_hour, m_minute, m_seconds_part};
                if (expected_dates.size() == 0) begin
                    report("unexpected result, year", 0, got.year);
                end else begin
                    want = expected_dates.pop_front();
                    if (got.year !== want.year)     report("year", want.year, got.year);
                    if (got.month !== want.month)   report("month", want.month, got.month);
                    if (got.day !== want.day)       report("day", want.day, got.day);
                    if (got.hour !== want.hour)     report("hour", want.hour, got.hour);
                    if (got.minute !== want.minute) report("minute", want.minute, got.minute);
                    if (got.second !== want.second) report("second", want.second, got.second);
                end
            end
            if (s_valid && s_ready)
                expected_dates.push_back(to_calendar(s_epoch_seconds));
            dates_outstanding = expected_dates.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the epoch-to-calendar converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
    import epcal_pkg::*;

    localparam int RANDOM_PER_PHASE = 275;
    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int DRAIN_CYCLES     = 400;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [EPOCH_W-1:0]  s_epoch_seconds = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [YEAR_W-1:0]   m_year;
    logic [MONTH_W-1:0]  m_month;
    logic [DAY_W-1:0]    m_day;
    logic [HOUR_W-1:0]   m_hour;
    logic [MINUTE_W-1:0] m_minute;
    logic [SEC_W-1:0]    m_seconds_part;

    int mismatches;
    int dates_outstanding;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int stall_pct       = 0;

    // Boundary instants: time-of-day rollovers, year ends, leap Februaries,
    // the non-leap century year 2100 and the top of the 32-bit range
    logic [EPOCH_W-1:0] corner_secs[$] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600, 32'd68255999,
        32'd68256000, 32'd94694399, 32'd951782400, 32'd978307199,
        32'd4107542399, 32'd4107542400, 32'd4133980799, 32'd4133980800,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
    };

    epoch_seconds_to_calendar uut (.*);

    epoch_calendar_checker checker_i (.*);

    always #5 aclk = ~aclk;

    // Randomize receiver back-pressure per cycle
    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Mix full-range values, midnight edges, short conversions and late dates
    function automatic logic [EPOCH_W-1:0] pick_epoch();
        logic [EPOCH_W-1:0] x;
        x = $urandom;
        case ($urandom_range(3))
            0: ;
            1: begin
                x = x - (x % SECS_DAY);
                if ($urandom_range(1)) x = x - 1;
            end
            2: x = $urandom_range(32'h03FF_FFFF);
            default: x = x | 32'hF000_0000;
        endcase
        return x;
    endfunction

    // Present one transaction and hold it until accepted
    task automatic send_epoch(input logic [EPOCH_W-1:0] secs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_secs[i]) send_epoch(corner_secs[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_epoch(pick_epoch());
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        @(posedge aclk);
        while (dates_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);

        if (mismatches == 0 && dates_outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/epcal_pkg.sv
hw/rtl/epcal_dp.sv
hw/rtl/epcal_ctrl.sv
hw/rtl/epoch_seconds_to_calendar.sv
verif/epoch_calendar_checker.sv
verif/tb.sv
